[hdl/edp_pkg.sv]
// ----------------------------------------------------------------------------
// edp_pkg
// Shared types, command codes and constants of the event duration profiler.
// ----------------------------------------------------------------------------
package edp_pkg;

   localparam int NUM_RECORDS = 16;
   localparam int ID_W        = 4;
   localparam int REC_W       = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
   localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
   localparam logic [39:0] MAX40      = 40'hFF_FFFF_FFFF;
   localparam logic [19:0] US_PER_S   = 20'd1000000;

   typedef enum logic [3:0] {
      CMD_BEGIN      = 4'd0,
      CMD_END        = 4'd1,
      CMD_UPDATE_ONE = 4'd2,
      CMD_UPDATE_ALL = 4'd3,
      CMD_RESET_ONE  = 4'd4,
      CMD_RESET_ALL  = 4'd5,
      CMD_START      = 4'd6,
      CMD_READ_ID    = 4'd7,
      CMD_READ_NEXT  = 4'd8,
      CMD_REWIND     = 4'd9
   } cmd_type;

   typedef struct packed {
      logic [3:0]  command;
      logic [3:0]  record_id;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_id;
      logic        active;
      logic [31:0] count_current;
      logic [31:0] count_last;
      logic [31:0] count_total;
      logic [31:0] min_last;
      logic [31:0] max_last;
      logic [31:0] min_total;
      logic [31:0] max_total;
      logic [39:0] avg_duration;
      logic [39:0] frequency;
   } rsp_type;

   // classified work item between front and back
   typedef struct packed {
      cmd_type     cmd;
      logic [REC_W-1:0] rec;
      logic [31:0] ts;
   } job_type;

endpackage

[hdl/event_duration_profiler_core.sv]
// ----------------------------------------------------------------------------
// event_duration_profiler_core
// Per-id timing monitor for sixteen records with interval statistics.
// ----------------------------------------------------------------------------
// Requests pass a four-deep queue to a sequencer. Begin, end, reset, start and
// read are taken in the idle state and done in the exec state; a read gives
// one response beat. An update of one record runs two serial divisions (one
// quotient bit a cycle) for rate and mean; a record with no events skips
// them. Update-all repeats the per-record part for every record. The queue
// takes new requests while the sequencer works, up to four ahead.
module event_duration_profiler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  edp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output edp_pkg::rsp_type  rsp_data
);
   import edp_pkg::*;

   logic    enable_ff;
   logic    job_valid, job_take;
   job_type job_data;

   always_ff @(posedge clock) begin
      if (reset)          enable_ff <= 1'b0;
      else if (csr_write) enable_ff <= csr_wdata;
   end

   edp_front u_front (
      .clock(clock), .reset(reset), .enable(enable_ff),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .job_valid(job_valid), .job_take(job_take), .job_data(job_data)
   );

   edp_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_take(job_take), .job_data(job_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

[hdl/edp_front.sv]
// ----------------------------------------------------------------------------
// edp_front
// Accepts requests, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
module edp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              req_valid,
   output logic              req_stall,
   input  edp_pkg::req_type  req_data,
   output logic              job_valid,
   input  logic              job_take,
   output edp_pkg::job_type  job_data
);
   import edp_pkg::*;

   localparam int QD = 4;
   job_type        q_ff [QD];
   logic [2:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]     cnt;
   logic           keep;
   logic           id_ok;
   job_type        nj;

   assign cnt       = wp_ff - rp_ff;
   assign req_stall = (cnt == 3'(QD));
   assign job_valid = (cnt != 3'd0);
   assign job_data  = q_ff[rp_ff[1:0]];
   assign id_ok     = ({28'd0, req_data.record_id} < 32'(NUM_RECORDS));

   always_comb begin
      nj.cmd = cmd_type'(req_data.command);
      nj.rec = req_data.record_id[REC_W-1:0];
      nj.ts  = req_data.timestamp;
      unique case (req_data.command)
         CMD_BEGIN, CMD_END, CMD_UPDATE_ONE: keep = enable && id_ok;
         CMD_UPDATE_ALL:                     keep = enable;
         CMD_RESET_ONE, CMD_READ_ID:         keep = id_ok;
         CMD_RESET_ALL, CMD_START, CMD_READ_NEXT, CMD_REWIND: keep = 1'b1;
         default:                            keep = 1'b0;
      endcase
      wp_in = wp_ff + 3'((req_valid && !req_stall && keep) ? 1 : 0);
      rp_in = rp_ff + 3'((job_valid && job_take) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall && keep) q_ff[wp_ff[1:0]] <= nj;
      if (reset) begin
         wp_ff <= 3'd0;
         rp_ff <= 3'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt <= 3'(QD)) else $error("queue overfilled");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (wp_ff == $past(wp_ff))) else $error("push while full");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (rp_ff != $past(rp_ff)) |-> $past(job_valid)) else $error("pop empty");
endmodule

[hdl/edp_divider.sv]
// ----------------------------------------------------------------------------
// edp_divider
// Restoring divider, one quotient bit a cycle, 64-bit dividend by 32-bit.
// ----------------------------------------------------------------------------
module edp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import edp_pkg::*;

   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [6:0]  n_ff, n_in;
   logic [32:0] t;

   assign done     = (n_ff == 7'd0);
   assign quotient = q_ff;

   always_comb begin
      t    = {r_ff[31:0], q_ff[63]};
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      if (start) begin
         q_in = dividend;
         r_in = 33'd0;
         n_in = 7'd64;
      end else if (n_ff != 7'd0) begin
         if (t >= {1'b0, d_ff}) begin
            r_in = t - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = t;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= divisor;
      if (reset) n_ff <= 7'd0;
      else       n_ff <= n_in;
   end
endmodule

[hdl/edp_back.sv]
// ----------------------------------------------------------------------------
// edp_back
// Record store and sequencer: executes queued jobs and emits read beats.
// ----------------------------------------------------------------------------
module edp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_take,
   input  edp_pkg::job_type  job_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output edp_pkg::rsp_type  rsp_data
);
   import edp_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_FETCH = 8'b0000_0010,
      S_EXEC  = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_DIV1  = 8'b0001_0000,
      S_DIV2  = 8'b0010_0000,
      S_WRITE = 8'b0100_0000,
      S_SWEEP = 8'b1000_0000
   } state_type;

   // per-record store; valid bits give reset values
   logic [31:0] bt_m [NUM_RECORDS];
   logic        act_ff [NUM_RECORDS];
   logic        ivld_ff [NUM_RECORDS];
   logic        cvld_ff [NUM_RECORDS];
   logic        lvld_ff [NUM_RECORDS];
   logic [31:0] icnt_m [NUM_RECORDS];
   logic [31:0] isum_m [NUM_RECORDS];
   logic [31:0] imin_m [NUM_RECORDS];
   logic [31:0] imax_m [NUM_RECORDS];
   logic [31:0] pcnt_m [NUM_RECORDS];
   logic [31:0] cmin_m [NUM_RECORDS];
   logic [31:0] cmax_m [NUM_RECORDS];
   logic [39:0] mean_m [NUM_RECORDS];
   logic [39:0] rate_m [NUM_RECORDS];
   logic [31:0] ltc_m  [NUM_RECORDS];
   logic [31:0] lmin_m [NUM_RECORDS];
   logic [31:0] lmax_m [NUM_RECORDS];
   logic        cvb_ff [NUM_RECORDS];
   logic        ltv_ff [NUM_RECORDS];
   logic        btv_ff [NUM_RECORDS];

   state_type        st_ff;
   state_type        exec_next;
   job_type          job_ff;
   logic [REC_W-1:0] k_ff, rp_ff;
   logic [31:0]      ist_ff, el_ff;
   logic [31:0]      r_bt, r_ic, r_is, r_imin, r_imax, r_pc, r_cmin, r_cmax;
   logic [31:0]      r_lc, r_lmin, r_lmax;
   logic [39:0]      r_mean, r_rate, rate_ff;
   logic [51:0]      prod_ff;
   logic             r_act;
   logic             rv_ff;
   logic             rsp_load;
   rsp_type          rsp_ff;
   logic             dv_start, dv_done;
   logic [63:0]      dv_num, dv_q;
   logic [31:0]      dv_den, dur;
   logic             div_sel_ff;
   logic             last_rec;

   edp_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_num),
      .divisor(dv_den), .done(dv_done), .quotient(dv_q)
   );

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign job_take  = (st_ff == S_IDLE) && job_valid;
   assign last_rec  = (k_ff == REC_W'(NUM_RECORDS - 1));
   assign dur       = job_ff.ts - r_bt;

   always_comb begin
      r_act  = act_ff[k_ff];
      r_bt   = btv_ff[k_ff] ? bt_m[k_ff] : 32'd0;
      r_ic   = ivld_ff[k_ff] ? icnt_m[k_ff] : 32'd0;
      r_is   = ivld_ff[k_ff] ? isum_m[k_ff] : 32'd0;
      r_imin = ivld_ff[k_ff] ? imin_m[k_ff] : ALL_ONES32;
      r_imax = ivld_ff[k_ff] ? imax_m[k_ff] : 32'd0;
      r_pc   = cvb_ff[k_ff] ? pcnt_m[k_ff] : 32'd0;
      r_cmin = cvld_ff[k_ff] ? cmin_m[k_ff] : ALL_ONES32;
      r_cmax = cvld_ff[k_ff] ? cmax_m[k_ff] : 32'd0;
      r_mean = cvb_ff[k_ff] ? mean_m[k_ff] : 40'd0;
      r_rate = cvb_ff[k_ff] ? rate_m[k_ff] : 40'd0;
      r_lc   = ltv_ff[k_ff] ? ltc_m[k_ff] : 32'd0;
      r_lmin = lvld_ff[k_ff] ? lmin_m[k_ff] : ALL_ONES32;
      r_lmax = lvld_ff[k_ff] ? lmax_m[k_ff] : 32'd0;
      rsp_load = (st_ff == S_EXEC) &&
                 (job_ff.cmd == CMD_READ_ID || job_ff.cmd == CMD_READ_NEXT) &&
                 !(rv_ff && rsp_stall);
      exec_next = S_IDLE;
      if ((job_ff.cmd == CMD_UPDATE_ONE || job_ff.cmd == CMD_UPDATE_ALL) &&
          el_ff != 32'd0)
         exec_next = S_FETCH;
      else if ((job_ff.cmd == CMD_READ_ID || job_ff.cmd == CMD_READ_NEXT) && !rsp_load)
         exec_next = S_EXEC;
      dv_start = 1'b0;
      dv_num   = 64'd0;
      dv_den   = el_ff;
      if (st_ff == S_MUL && r_ic != 32'd0) begin
         dv_start = 1'b1;
         dv_num   = {4'd0, prod_ff, 8'd0};
      end else if (st_ff == S_DIV1 && dv_done && div_sel_ff) begin
         dv_start = 1'b1;
         dv_num   = {24'd0, r_is, 8'd0};
         dv_den   = r_ic;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         rp_ff <= '0;
         ist_ff <= 32'd0;
         div_sel_ff <= 1'b0;
         for (int i = 0; i < NUM_RECORDS; i++) begin
            act_ff[i] <= 1'b0; ivld_ff[i] <= 1'b0; cvld_ff[i] <= 1'b0;
            lvld_ff[i] <= 1'b0; cvb_ff[i] <= 1'b0; ltv_ff[i] <= 1'b0;
            btv_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_load) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  k_ff   <= (job_data.cmd == CMD_READ_NEXT) ? rp_ff :
                            (job_data.cmd == CMD_UPDATE_ALL) ? '0 : job_data.rec;
                  el_ff  <= job_data.ts - ist_ff;
                  st_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               st_ff <= exec_next;
               case (job_ff.cmd)
                  CMD_BEGIN: begin
                     bt_m[k_ff] <= job_ff.ts; btv_ff[k_ff] <= 1'b1;
                     act_ff[k_ff] <= 1'b1;
                  end
                  CMD_END: if (r_act) begin
                     act_ff[k_ff] <= 1'b0;
                     icnt_m[k_ff] <= r_ic + 32'd1;
                     isum_m[k_ff] <= r_is + dur;
                     imin_m[k_ff] <= (dur < r_imin) ? dur : r_imin;
                     imax_m[k_ff] <= (dur > r_imax) ? dur : r_imax;
                     ivld_ff[k_ff] <= 1'b1;
                     ltc_m[k_ff]  <= r_lc + 32'd1; ltv_ff[k_ff] <= 1'b1;
                     lmin_m[k_ff] <= (dur < r_lmin) ? dur : r_lmin;
                     lmax_m[k_ff] <= (dur > r_lmax) ? dur : r_lmax;
                     lvld_ff[k_ff] <= 1'b1;
                  end
                  CMD_RESET_ONE: lvld_ff[k_ff] <= 1'b0;
                  CMD_RESET_ALL:
                     for (int i = 0; i < NUM_RECORDS; i++) lvld_ff[i] <= 1'b0;
                  CMD_START: begin
                     for (int i = 0; i < NUM_RECORDS; i++) ivld_ff[i] <= 1'b0;
                     ist_ff <= job_ff.ts;
                  end
                  CMD_READ_ID, CMD_READ_NEXT: begin
                     if (rsp_load) begin
                        rsp_ff <= '{out_id: ID_W'(k_ff), active: r_act,
                           count_current: r_ic, count_last: r_pc,
                           count_total: r_lc, min_last: r_cmin,
                           max_last: r_cmax, min_total: r_lmin,
                           max_total: r_lmax, avg_duration: r_mean,
                           frequency: r_rate};
                        if (job_ff.cmd == CMD_READ_NEXT)
                           rp_ff <= (k_ff == REC_W'(NUM_RECORDS - 1)) ?
                                    '0 : k_ff + REC_W'(1);
                     end
                  end
                  CMD_REWIND: rp_ff <= '0;
                  default: ;
               endcase
            end
            S_FETCH: begin
               prod_ff <= 52'(r_ic) * 52'(US_PER_S);
               st_ff <= S_MUL;
            end
            S_MUL: begin
               div_sel_ff <= 1'b1;
               st_ff <= (r_ic != 32'd0) ? S_DIV1 : S_WRITE;
            end
            S_DIV1: if (dv_done) begin
               rate_ff <= (dv_q > {24'd0, MAX40}) ? MAX40 : dv_q[39:0];
               div_sel_ff <= 1'b0;
               st_ff <= S_DIV2;
            end
            S_DIV2: if (dv_done) st_ff <= S_WRITE;
            S_WRITE: begin
               cvb_ff[k_ff] <= 1'b1; cvld_ff[k_ff] <= 1'b1;
               pcnt_m[k_ff] <= r_ic;
               if (r_ic != 32'd0) begin
                  mean_m[k_ff] <= dv_q[39:0]; rate_m[k_ff] <= rate_ff;
                  cmin_m[k_ff] <= r_imin; cmax_m[k_ff] <= r_imax;
               end else begin
                  mean_m[k_ff] <= 40'd0; rate_m[k_ff] <= 40'd0;
                  cmin_m[k_ff] <= 32'd0; cmax_m[k_ff] <= 32'd0;
               end
               ivld_ff[k_ff] <= 1'b0;
               st_ff <= S_SWEEP;
            end
            S_SWEEP: begin
               st_ff <= (job_ff.cmd == CMD_UPDATE_ALL && !last_rec) ? S_FETCH : S_IDLE;
               if (job_ff.cmd == CMD_UPDATE_ALL && !last_rec) k_ff <= k_ff + REC_W'(1);
               if (last_rec) ist_ff <= job_ff.ts;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("state not one-hot");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |=> (st_ff == S_EXEC)) else $error("take outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> $stable(rsp_ff)) else $error("beat changed");
endmodule
